// File: src/vrp_pkg.sv
// Shared types and constants for the video register port.
// No dependencies; used by vrp_ctrl, vrp_dp and the top level.
package vrp_pkg;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // register numbers
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPADDR = 3'd3;
    localparam logic [2:0] REG_SPDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    // nametable mirroring modes
    localparam logic [1:0] MIR_HORIZ  = 2'd0;
    localparam logic [1:0] MIR_VERT   = 2'd1;
    localparam logic [1:0] MIR_SINGLE = 2'd2;
    localparam logic [1:0] MIR_FOUR   = 2'd3;

    localparam int unsigned SPRITE_MEM_DEPTH = 256;
    localparam int unsigned SPRITE_AW        = 8;

    localparam logic [7:0]  SCROLL_X_MAX  = 8'd240;
    localparam logic [7:0]  ROW_FIRST     = 8'd0;
    localparam logic [7:0]  ROW_VBLANK    = 8'd239;
    localparam logic [7:0]  FIRST_READ    = 8'hFF;
    localparam logic [13:0] PAL_BACKDROP  = 14'h3F10;
    localparam logic [5:0]  PAL_PAGE      = 6'h3F;
    localparam logic [15:0] INC_ACROSS    = 16'd1;
    localparam logic [15:0] INC_DOWN      = 16'd32;

    // controller to datapath
    typedef struct packed {
        logic clearing;
        logic capture;
        logic access;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
    } t_dp_status;

endpackage

// File: src/vrp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module vrp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/vrp_ctrl.sv
// Sequencing controller: clearing pass, then accept / access / finish per item.
// Depends on vrp_pkg.
module vrp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  vrp_pkg::t_dp_status i_status,
    output vrp_pkg::t_dp_cmd    o_cmd,
    output logic                busy,
    output logic                o_done
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_ACCESS = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (i_status.clear_done) n_state = ST_IDLE;
            ST_IDLE:   if (start) n_state = ST_ACCESS;
            ST_ACCESS: n_state = ST_FINISH;
            ST_FINISH: n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_FINISH);
        end
    end

    assign o_cmd.clearing = (r_state == ST_CLEAR);
    assign o_cmd.capture  = (r_state == ST_IDLE) && start;
    assign o_cmd.access   = (r_state == ST_ACCESS);
    assign o_cmd.commit   = (r_state == ST_FINISH);
    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;

endmodule

// File: src/vrp_dp.sv
// Datapath: register file, address and scroll latches, palettes, address map,
// video and sprite RAMs. Depends on vrp_pkg and vrp_ram.
module vrp_dp #(
    parameter int unsigned VRAM_DEPTH = 16384
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vrp_pkg::t_dp_cmd    i_cmd,
    output vrp_pkg::t_dp_status o_status,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_wdata,
    input  logic [1:0]          i_req_type,
    input  logic [2:0]          i_reg_index,
    input  logic [7:0]          i_data,
    input  logic [12:0]         i_load_addr,
    input  logic [7:0]          i_row,
    output logic [7:0]          o_read_data,
    output logic [7:0]          o_scroll_x,
    output logic [7:0]          o_scroll_y,
    output logic                o_vblank
);

    localparam int unsigned AW          = $clog2(VRAM_DEPTH);
    localparam int unsigned SPRITE_AW_L = vrp_pkg::SPRITE_AW;

    // latched item
    logic [1:0]  r_req_type;
    logic [2:0]  r_reg_index;
    logic [7:0]  r_data;
    logic [12:0] r_load_addr;
    logic [7:0]  r_row;

    // architectural state
    logic [1:0]  r_mirror;
    logic [7:0]  r_rf [8];
    logic [15:0] r_vram_addr;
    logic        r_addr_second;
    logic        r_scroll_second;
    logic        r_first_read;
    logic [7:0]  r_scroll_x;
    logic [7:0]  r_scroll_y;
    logic [7:0]  r_sprite_ptr;
    logic [5:0]  r_bg_pal [16];
    logic [5:0]  r_sp_pal [16];
    logic [7:0]  r_read_data;
    logic [AW-1:0] r_clr_cnt;

    // address map
    logic        dead;
    logic [13:0] a;
    logic        is_pat;
    logic        is_pal;
    logic        is_nt;
    logic [13:0] nt_idx;
    logic [13:0] mem_idx;
    logic [5:0]  pal_rd;
    logic [7:0]  vram_val;
    logic [15:0] addr_inc;
    logic        is_wr;

    logic          vram_we;
    logic [AW-1:0] vram_addr;
    logic [7:0]    vram_wdata;
    logic [7:0]    vram_rdata;
    logic          spr_we;
    logic [SPRITE_AW_L-1:0] spr_addr;
    logic [7:0]    spr_wdata;
    logic [7:0]    spr_rdata;

    assign dead   = &r_vram_addr[15:14];
    assign a      = r_vram_addr[13:0];
    assign is_pat = !a[13];
    assign is_pal = (a[13:8] == vrp_pkg::PAL_PAGE);
    assign is_nt  = a[13] && !is_pal;
    assign is_wr  = (r_req_type == vrp_pkg::REQ_WRITE);

    // bit 12 is dropped, so 0x3000-0x3EFF lands on 0x2000
    always_comb begin
        unique case (r_mirror)
            vrp_pkg::MIR_HORIZ:  nt_idx = {3'b100, a[11], a[9:0]};
            vrp_pkg::MIR_VERT:   nt_idx = {3'b100, a[10], a[9:0]};
            vrp_pkg::MIR_SINGLE: nt_idx = {3'b100, 1'b0, a[9:0]};
            vrp_pkg::MIR_FOUR:   nt_idx = {2'b10, a[11:0]};
            default:             nt_idx = {2'b10, a[11:0]};
        endcase
    end

    assign mem_idx  = is_pat ? a : nt_idx;
    assign pal_rd   = a[4] ? r_sp_pal[a[3:0]] : r_bg_pal[a[3:0]];
    assign vram_val = dead   ? 8'h00 :
                      is_pal ? {2'b00, pal_rd} : vram_rdata;
    assign addr_inc = r_rf[vrp_pkg::REG_CTRL][2] ? vrp_pkg::INC_DOWN : vrp_pkg::INC_ACROSS;

    // RAM ports: clearing pass, else the access cycle of the item
    always_comb begin
        vram_we    = 1'b0;
        vram_addr  = AW'(mem_idx);
        vram_wdata = r_data;
        spr_we     = 1'b0;
        spr_addr   = r_sprite_ptr;
        spr_wdata  = r_data;
        if (i_cmd.clearing) begin
            vram_we    = 1'b1;
            vram_addr  = r_clr_cnt;
            vram_wdata = 8'h00;
            spr_we     = (r_clr_cnt[AW-1:SPRITE_AW_L] == '0);
            spr_addr   = r_clr_cnt[SPRITE_AW_L-1:0];
            spr_wdata  = 8'h00;
        end else begin
            if (r_req_type == vrp_pkg::REQ_LOAD) begin
                vram_addr = AW'(r_load_addr);
            end
            if (i_cmd.access) begin
                vram_we = (r_req_type == vrp_pkg::REQ_LOAD) ||
                          (is_wr && (r_reg_index == vrp_pkg::REG_DATA) && !dead && is_nt);
                spr_we  = is_wr && (r_reg_index == vrp_pkg::REG_SPDATA);
            end
        end
    end

    assign o_status.clear_done = (r_clr_cnt == AW'(VRAM_DEPTH - 1));

    vrp_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_addr  (vram_addr),
        .i_wdata (vram_wdata),
        .o_rdata (vram_rdata)
    );

    vrp_ram #(.WIDTH(8), .DEPTH(vrp_pkg::SPRITE_MEM_DEPTH)) u_spr (
        .i_clk   (i_clk),
        .i_we    (spr_we),
        .i_addr  (spr_addr),
        .i_wdata (spr_wdata),
        .o_rdata (spr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type  <= i_req_type;
            r_reg_index <= i_reg_index;
            r_data      <= i_data;
            r_load_addr <= i_load_addr;
            r_row       <= i_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clearing && !o_status.clear_done) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror <= vrp_pkg::MIR_HORIZ;
        end else if (i_cfg_we) begin
            r_mirror <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_rf[i] <= 8'h00;
            end
            for (int i = 0; i < 16; i++) begin
                r_bg_pal[i] <= 6'h00;
                r_sp_pal[i] <= 6'h00;
            end
            r_vram_addr     <= 16'h0000;
            r_addr_second   <= 1'b0;
            r_scroll_second <= 1'b0;
            r_first_read    <= 1'b1;
            r_scroll_x      <= 8'h00;
            r_scroll_y      <= 8'h00;
            r_sprite_ptr    <= 8'h00;
            r_read_data     <= 8'h00;
        end else if (i_cmd.commit) begin
            r_read_data <= 8'h00;
            unique case (r_req_type)
                vrp_pkg::REQ_WRITE: begin
                    unique case (r_reg_index)
                        vrp_pkg::REG_CTRL, vrp_pkg::REG_MASK: begin
                            r_rf[r_reg_index] <= r_data;
                        end
                        vrp_pkg::REG_STATUS: ;
                        vrp_pkg::REG_SPADDR: begin
                            r_rf[vrp_pkg::REG_SPADDR] <= r_data;
                            r_sprite_ptr <= r_data;
                        end
                        vrp_pkg::REG_SPDATA: begin
                            r_rf[vrp_pkg::REG_SPDATA] <= r_data;
                            r_sprite_ptr <= r_sprite_ptr + 8'd1;
                        end
                        vrp_pkg::REG_SCROLL: begin
                            r_rf[vrp_pkg::REG_SCROLL] <= r_data;
                            if (!r_scroll_second) begin
                                if (r_data <= vrp_pkg::SCROLL_X_MAX) r_scroll_x <= r_data;
                                r_scroll_second <= 1'b1;
                            end else begin
                                r_scroll_y      <= r_data;
                                r_scroll_second <= 1'b0;
                            end
                        end
                        vrp_pkg::REG_ADDR: begin
                            r_rf[vrp_pkg::REG_ADDR] <= r_data;
                            if (!r_addr_second) begin
                                r_vram_addr   <= {2'b00, r_data[5:0], 8'h00};
                                r_addr_second <= 1'b1;
                            end else begin
                                r_vram_addr   <= r_vram_addr | {8'h00, r_data};
                                r_addr_second <= 1'b0;
                                r_first_read  <= 1'b1;
                            end
                        end
                        vrp_pkg::REG_DATA: begin
                            r_rf[vrp_pkg::REG_DATA] <= r_data;
                            if (!dead && is_pal) begin
                                // backdrop write mirrors into every fourth entry
                                if (a == vrp_pkg::PAL_BACKDROP) begin
                                    for (int k = 0; k < 16; k += 4) begin
                                        r_bg_pal[k] <= r_data[5:0];
                                        r_sp_pal[k] <= r_data[5:0];
                                    end
                                end
                                if (a[4]) r_sp_pal[a[3:0]] <= r_data[5:0];
                                else      r_bg_pal[a[3:0]] <= r_data[5:0];
                            end
                            r_vram_addr <= r_vram_addr + addr_inc;
                        end
                        default: ;
                    endcase
                end
                vrp_pkg::REQ_READ: begin
                    unique case (r_reg_index)
                        vrp_pkg::REG_STATUS: begin
                            r_read_data <= r_rf[vrp_pkg::REG_STATUS];
                            r_rf[vrp_pkg::REG_STATUS][7] <= 1'b0;
                            r_addr_second   <= 1'b0;
                            r_scroll_second <= 1'b0;
                        end
                        vrp_pkg::REG_SPDATA: begin
                            r_read_data <= spr_rdata;
                            r_rf[vrp_pkg::REG_SPDATA] <= spr_rdata;
                            r_sprite_ptr <= r_sprite_ptr + 8'd1;
                        end
                        vrp_pkg::REG_DATA: begin
                            if (r_first_read) begin
                                r_read_data <= vrp_pkg::FIRST_READ;
                                r_rf[vrp_pkg::REG_DATA] <= vrp_pkg::FIRST_READ;
                                r_first_read <= 1'b0;
                            end else begin
                                r_read_data <= vram_val;
                                r_rf[vrp_pkg::REG_DATA] <= vram_val;
                                r_vram_addr <= r_vram_addr + addr_inc;
                            end
                        end
                        vrp_pkg::REG_CTRL, vrp_pkg::REG_MASK, vrp_pkg::REG_SPADDR,
                        vrp_pkg::REG_SCROLL, vrp_pkg::REG_ADDR: begin
                            r_read_data <= r_rf[r_reg_index];
                        end
                        default: ;
                    endcase
                end
                vrp_pkg::REQ_LOAD: ;
                vrp_pkg::REQ_TICK: begin
                    if (r_row == vrp_pkg::ROW_FIRST) begin
                        r_rf[vrp_pkg::REG_STATUS][7:6] <= 2'b00;
                    end
                    if (r_row == vrp_pkg::ROW_VBLANK) begin
                        r_rf[vrp_pkg::REG_STATUS][7] <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_read_data = r_read_data;
    assign o_scroll_x  = r_scroll_x;
    assign o_scroll_y  = r_scroll_y;
    assign o_vblank    = r_rf[vrp_pkg::REG_STATUS][7];

endmodule

// File: src/video_register_port_core.sv
// Video register port, top level: controller plus datapath.
// Sequence per item: capture, one video/sprite RAM access, commit; o_done and the result
// are registered at the commit, and the next item is accepted only after it.
// Reset: synchronous, active low; a clearing pass then zeroes video and sprite RAM,
// one entry a cycle until every video RAM entry is written, with busy held high.
// Results cannot be stalled; each stays on the ports for the strobe cycle.
module video_register_port_core #(
    parameter int unsigned VRAM_DEPTH = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_data,
    input  logic [12:0] i_load_addr,
    input  logic [7:0]  i_row,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_scroll_x,
    output logic [7:0]  o_scroll_y,
    output logic        o_vblank
);

    vrp_pkg::t_dp_cmd    cmd;
    vrp_pkg::t_dp_status status;

    vrp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    vrp_dp #(.VRAM_DEPTH(VRAM_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_type  (i_req_type),
        .i_reg_index (i_reg_index),
        .i_data      (i_data),
        .i_load_addr (i_load_addr),
        .i_row       (i_row),
        .o_read_data (o_read_data),
        .o_scroll_x  (o_scroll_x),
        .o_scroll_y  (o_scroll_y),
        .o_vblank    (o_vblank)
    );

endmodule

// File: src/vrp_checker.sv
// Port-level checks on item sequencing, bound to the top level.
// Depends only on the top-level ports.
module vrp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // an accepted item always yields its result strobe
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##2 o_done)
        else $error("item accepted without result strobe");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after item accepted");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

endmodule

bind video_register_port_core vrp_checker u_vrp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
